/* sv/skbs_pkg.sv */
// Shared types, constants and helpers for the sorted key binary search unit.
`timescale 1ns / 1ps

package skbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_BITS    = 64;
	localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int RANGE_BITS  = ADDR_BITS + 1;

	localparam int INDEX_BITS  = 8;
	localparam int NAME_BITS   = 64;
	localparam int POS_BITS    = 8;
	localparam int COUNT_BITS  = 9;

	localparam int PADDR_BITS  = 3;
	localparam int PDATA_BITS  = 32;

	// word index of the entry_count register
	localparam logic [PADDR_BITS-3:0] REG_ENTRY_COUNT = '0;

	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SEARCH = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic                  req_type;
		logic [INDEX_BITS-1:0] entry_index;
		logic [NAME_BITS-1:0]  name_key;
	} in_item_t;

	typedef struct packed {
		logic                found;
		logic [POS_BITS-1:0] position;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_FINISH
	} srch_state_t;

	typedef struct packed {
		logic                 wr_en;
		logic [ADDR_BITS-1:0] wr_addr;
		logic [KEY_BITS-1:0]  wr_data;
		logic                 rd_en;
		logic [ADDR_BITS-1:0] rd_addr;
	} ram_req_t;

	// clamp the programmed count to the table depth
	function automatic logic [RANGE_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] cnt);
		if (cnt > TABLE_DEPTH) begin
			return RANGE_BITS'(TABLE_DEPTH);
		end
		return RANGE_BITS'(cnt);
	endfunction

endpackage

/* sv/skbs_key_ram.sv */
// Key table: one write port, one registered read port.
`timescale 1ns / 1ps

module skbs_key_ram (
	input  logic                               clk,
	input  skbs_pkg::ram_req_t                 req,
	output logic [skbs_pkg::KEY_BITS-1:0]      rd_data
);

	logic [skbs_pkg::KEY_BITS-1:0] mem [skbs_pkg::TABLE_DEPTH];
	logic [skbs_pkg::KEY_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/skbs_ctrl.sv */
// Search sequencer: range registers, probe address and the shared key compare.
`timescale 1ns / 1ps

module skbs_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  skbs_pkg::in_item_t                  in_data,
	input  logic [skbs_pkg::COUNT_BITS-1:0]     entry_count,
	input  logic                                res_free,
	input  logic [skbs_pkg::KEY_BITS-1:0]       rd_data,
	output logic                                ready,
	output skbs_pkg::ram_req_t                  ram_req,
	output logic                                res_load,
	output skbs_pkg::out_item_t                 res
);

	skbs_pkg::srch_state_t state_q, state_d;

	logic [skbs_pkg::RANGE_BITS-1:0] lo_q;
	logic [skbs_pkg::RANGE_BITS-1:0] hi_q;      // exclusive upper bound
	logic [skbs_pkg::ADDR_BITS-1:0]  mid_q;
	logic [skbs_pkg::KEY_BITS-1:0]   key_q;
	logic                            found_q;

	logic                            accept;
	logic                            is_search;
	logic                            wr_in_range;
	logic [skbs_pkg::RANGE_BITS:0]   mid_sum;
	logic [skbs_pkg::ADDR_BITS-1:0]  mid_w;
	logic [skbs_pkg::RANGE_BITS-1:0] mid_ext;
	logic [skbs_pkg::RANGE_BITS-1:0] lo_next;
	logic                            probe_gt;
	logic                            probe_lt;
	logic [skbs_pkg::RANGE_BITS-1:0] start_hi;

	assign accept      = in_valid && ready;
	assign is_search   = (in_data.req_type == skbs_pkg::REQ_SEARCH);
	assign wr_in_range = (in_data.entry_index < skbs_pkg::TABLE_DEPTH);
	assign start_hi    = skbs_pkg::sat_count(entry_count);

	// mid = (lo + hi - 1) / 2, range is never empty here
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - 1'b1;
	assign mid_w   = mid_sum[skbs_pkg::ADDR_BITS:1];
	assign mid_ext = {1'b0, mid_q};
	assign lo_next = mid_ext + 1'b1;

	assign probe_gt = (rd_data > key_q);
	assign probe_lt = (rd_data < key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skbs_pkg::ST_IDLE: begin
				if (accept && is_search) begin
					state_d = (start_hi == '0) ? skbs_pkg::ST_FINISH : skbs_pkg::ST_PROBE;
				end
			end
			skbs_pkg::ST_PROBE: begin
				state_d = skbs_pkg::ST_CMP;
			end
			skbs_pkg::ST_CMP: begin
				priority if (probe_gt) begin
					state_d = (lo_q < mid_ext) ? skbs_pkg::ST_PROBE : skbs_pkg::ST_FINISH;
				end else if (probe_lt) begin
					state_d = (lo_next < hi_q) ? skbs_pkg::ST_PROBE : skbs_pkg::ST_FINISH;
				end else begin
					state_d = skbs_pkg::ST_FINISH;
				end
			end
			skbs_pkg::ST_FINISH: begin
				if (res_free) begin
					state_d = skbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skbs_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ready            = 1'b0;
		res_load         = 1'b0;
		ram_req.wr_en    = 1'b0;
		ram_req.wr_addr  = skbs_pkg::ADDR_BITS'(in_data.entry_index);
		ram_req.wr_data  = in_data.name_key[skbs_pkg::KEY_BITS-1:0];
		ram_req.rd_en    = 1'b0;
		ram_req.rd_addr  = mid_w;
		unique case (state_q)
			skbs_pkg::ST_IDLE: begin
				ready         = 1'b1;
				ram_req.wr_en = in_valid && !is_search && wr_in_range;
			end
			skbs_pkg::ST_PROBE: begin
				ram_req.rd_en = 1'b1;
			end
			skbs_pkg::ST_CMP: begin
			end
			skbs_pkg::ST_FINISH: begin
				res_load = res_free;
			end
			default: begin
			end
		endcase
	end

	assign res.found    = found_q;
	assign res.position = found_q ? skbs_pkg::POS_BITS'(mid_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// range and key registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			skbs_pkg::ST_IDLE: begin
				if (accept && is_search) begin
					lo_q    <= '0;
					hi_q    <= start_hi;
					key_q   <= in_data.name_key[skbs_pkg::KEY_BITS-1:0];
					found_q <= 1'b0;
				end
			end
			skbs_pkg::ST_PROBE: begin
				mid_q <= mid_w;
			end
			skbs_pkg::ST_CMP: begin
				priority if (probe_gt) begin
					hi_q <= mid_ext;
				end else if (probe_lt) begin
					lo_q <= lo_next;
				end else begin
					found_q <= 1'b1;
				end
			end
			skbs_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

/* sv/sorted_key_binary_search_unit.sv */
// Top level: request/result channels, entry_count register and result register.
//
//   channel   direction  handshake             payload
//   request   in         in_valid / in_stall   in_data  (skbs_pkg::in_item_t)
//   result    out        out_valid / out_stall out_data (skbs_pkg::out_item_t)
//   config    in         APB psel/penable      pwdata / prdata, entry_count at 0x0
//
// A write request is written to the key table when accepted in ST_IDLE. A search runs
// each probe as the registered table read in ST_PROBE and then the key compare in
// ST_CMP, after a start in ST_IDLE and before ST_FINISH, which waits for a free result register.
// Reset clears entry_count and the control state; the key table is not cleared.
// in_stall is high from a search's acceptance until its result enters the result
// register, which holds it while out_stall is high.
`timescale 1ns / 1ps

module sorted_key_binary_search_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  skbs_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output skbs_pkg::out_item_t                  out_data,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [skbs_pkg::PADDR_BITS-1:0]      paddr,
	input  logic [skbs_pkg::PDATA_BITS-1:0]      pwdata,
	output logic [skbs_pkg::PDATA_BITS-1:0]      prdata,
	output logic                                 pready
);

	logic [skbs_pkg::COUNT_BITS-1:0] entry_count_q;
	logic                            out_valid_q;
	skbs_pkg::out_item_t             out_q;

	logic                            ready;
	logic                            res_load;
	logic                            res_free;
	skbs_pkg::out_item_t             res;
	skbs_pkg::ram_req_t              ram_req;
	logic [skbs_pkg::KEY_BITS-1:0]   rd_data;
	logic                            reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[skbs_pkg::PADDR_BITS-1:2] == skbs_pkg::REG_ENTRY_COUNT);
	assign prdata  = reg_hit ? skbs_pkg::PDATA_BITS'(entry_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			entry_count_q <= pwdata[skbs_pkg::COUNT_BITS-1:0];
		end
	end

	skbs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_data     (in_data),
		.entry_count (entry_count_q),
		.res_free    (res_free),
		.rd_data     (rd_data),
		.ready       (ready),
		.ram_req     (ram_req),
		.res_load    (res_load),
		.res         (res)
	);

	skbs_key_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	assign in_stall = !ready;

	// result register: load when empty or being drained
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_search_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == skbs_pkg::REQ_SEARCH |=> in_stall)
		else $error("request accepted right after a search");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.position == '0)
		else $error("miss result carries a nonzero position");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == skbs_pkg::REQ_WRITE && !out_valid
		|=> !out_valid)
		else $error("write request produced a result");

endmodule
